>>> rtl/i8dpr_pkg.sv
package i8dpr_pkg;

	// Result queue between MAC front and requantization back
	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW    = $clog2(QDEPTH + 1);

	// Configuration register indexes
	localparam logic [1:0] REG_IN_ZP   = 2'd0;
	localparam logic [1:0] REG_OUT_ZP  = 2'd1;
	localparam logic [1:0] REG_ACT_MIN = 2'd2;
	localparam logic [1:0] REG_ACT_MAX = 2'd3;

	// Fixed-point constants of the doubling high multiply
	localparam logic signed [63:0] ROUND_HALF = 64'sh0000_0000_4000_0000;
	localparam logic signed [31:0] INT32_MIN  = 32'sh8000_0000;
	localparam logic signed [31:0] INT32_MAX  = 32'sh7fff_ffff;

	typedef struct packed {
		logic signed [7:0] in_zp;
		logic signed [7:0] out_zp;
		logic signed [7:0] act_min;
		logic signed [7:0] act_max;
	} cfg_t;

	// One finished neuron waiting for requantization
	typedef struct packed {
		logic signed [31:0] acc;
		logic signed [31:0] mult;
		logic signed [5:0]  shift;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

>>> rtl/i8dpr_front.sv
module i8dpr_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [7:0]      activation,
	input  logic signed [7:0]      weight,
	input  logic                   first_of_run,
	input  logic signed [31:0]     bias,
	input  logic signed [31:0]     scale_multiplier,
	input  logic signed [5:0]      scale_shift,
	input  logic                   last_of_run,
	input  i8dpr_pkg::cfg_t        cfg,
	input  i8dpr_pkg::qstat_t      qstat,
	output logic                   push,
	output i8dpr_pkg::job_t        job
);
	import i8dpr_pkg::*;

	logic signed [31:0] acc_q;
	logic signed [8:0]  act_off;
	logic signed [16:0] prod;
	logic signed [31:0] acc_base;
	logic signed [31:0] acc_next;
	logic               accept;

	// Hold input while the queue has no room for a finished neuron
	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	// Multiply-accumulate with 32-bit wrap
	assign act_off  = {activation[7], activation} - {cfg.in_zp[7], cfg.in_zp};
	assign prod     = act_off * weight;
	assign acc_base = first_of_run ? bias : acc_q;
	assign acc_next = acc_base + {{15{prod[16]}}, prod};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (accept) begin
			acc_q <= acc_next;
		end
	end

	// Hand the finished sum to the queue on the last pair
	assign push       = accept && last_of_run;
	assign job.acc    = acc_next;
	assign job.mult   = scale_multiplier;
	assign job.shift  = scale_shift;

endmodule

>>> rtl/i8dpr_queue.sv
module i8dpr_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  i8dpr_pkg::job_t        wr_job,
	input  logic                   pop,
	output i8dpr_pkg::job_t        head,
	output i8dpr_pkg::qstat_t      qstat
);
	import i8dpr_pkg::*;

	job_t             entry_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
		logic [QAW-1:0] r;
		r = (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	assign qstat.full  = (count_q == QCW'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = entry_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/i8dpr_back.sv
module i8dpr_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  i8dpr_pkg::job_t        head,
	input  i8dpr_pkg::qstat_t      qstat,
	output logic                   pop,
	input  i8dpr_pkg::cfg_t        cfg,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [7:0]      neuron_value
);
	import i8dpr_pkg::*;

	logic               adv;
	logic               valid_s1, valid_s2, valid_s3, out_valid_q;
	logic signed [63:0] prod_s1;
	logic               sat_s1;
	logic signed [5:0]  shift_s1, shift_s2;
	logic signed [31:0] high_s2;
	logic signed [31:0] scaled_s3;
	logic signed [7:0]  neuron_value_q;

	logic signed [63:0] prod;
	logic signed [63:0] rsum;
	logic signed [31:0] high;
	logic signed [32:0] high_ext;
	logic [5:0]         rsh;
	logic signed [32:0] quot;
	logic               rnd;
	logic signed [31:0] scaled;
	logic signed [32:0] zsum;
	logic signed [32:0] lo_ext;
	logic signed [32:0] hi_ext;
	logic signed [7:0]  clamped;

	// Pipeline moves whenever the output register can take a value
	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !qstat.empty;

	// Stage 1: full product and saturation case
	assign prod = head.acc * head.mult;

	// Stage 2: round to nearest and keep the high word
	assign rsum = prod_s1 + ROUND_HALF;
	assign high = sat_s1 ? INT32_MAX : rsum[62:31];

	// Stage 3: wrapping left shift or rounding right shift
	assign high_ext = {high_s2[31], high_s2};
	assign rsh      = 6'd0 - shift_s2;
	assign quot     = high_ext >>> rsh;
	assign rnd      = high_s2[~shift_s2[4:0]];
	always_comb begin
		if (!shift_s2[5]) begin
			scaled = high_s2 << shift_s2[4:0];
		end else begin
			scaled = quot[31:0] + {31'd0, rnd};
		end
	end

	// Stage 4: output zero point and clamp
	assign zsum   = {scaled_s3[31], scaled_s3} + {{25{cfg.out_zp[7]}}, cfg.out_zp};
	assign lo_ext = {{25{cfg.act_min[7]}}, cfg.act_min};
	assign hi_ext = {{25{cfg.act_max[7]}}, cfg.act_max};
	always_comb begin
		priority if (zsum < lo_ext) begin
			clamped = cfg.act_min;
		end else if (zsum > hi_ext) begin
			clamped = cfg.act_max;
		end else begin
			clamped = zsum[7:0];
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1        <= prod;
			sat_s1         <= (head.acc == INT32_MIN) && (head.mult == INT32_MIN);
			shift_s1       <= head.shift;
			high_s2        <= high;
			shift_s2       <= shift_s1;
			scaled_s3      <= scaled;
			neuron_value_q <= clamped;
		end
	end

	assign out_valid    = out_valid_q;
	assign neuron_value = neuron_value_q;

endmodule

>>> rtl/int8_dot_product_requant_unit.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  activation, weight, first_of_run, bias,
//                                           scale_multiplier, scale_shift, last_of_run
// output    out        out_valid / out_stall neuron_value
// config    in         wr_en                wr_index, wr_data
//
// One (activation, weight) pair is taken per cycle while in_stall is low; the MAC adds each pair into its register.
// After its last pair a neuron's sum is queued, then registered through the multiply, round, shift and clamp stages.
// A two-entry queue holds finished sums; input stalls only while that queue is full.
// Reset clears the accumulator, empties the queue and loads the default zero points
// and clamp bounds. A stalled output holding a valid value freezes the whole requantization pipeline.
module int8_dot_product_requant_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [7:0]  activation,
	input  logic signed [7:0]  weight,
	input  logic               first_of_run,
	input  logic signed [31:0] bias,
	input  logic signed [31:0] scale_multiplier,
	input  logic signed [5:0]  scale_shift,
	input  logic               last_of_run,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [7:0]  neuron_value,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [7:0]         wr_data
);
	import i8dpr_pkg::*;

	cfg_t   cfg_q;
	job_t   push_job;
	job_t   head;
	qstat_t qstat;
	logic   push;
	logic   pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.in_zp   <= 8'sd0;
			cfg_q.out_zp  <= 8'sd0;
			cfg_q.act_min <= -8'sd128;
			cfg_q.act_max <= 8'sd127;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_IN_ZP:   cfg_q.in_zp   <= wr_data;
				REG_OUT_ZP:  cfg_q.out_zp  <= wr_data;
				REG_ACT_MIN: cfg_q.act_min <= wr_data;
				REG_ACT_MAX: cfg_q.act_max <= wr_data;
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	i8dpr_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.activation       (activation),
		.weight           (weight),
		.first_of_run     (first_of_run),
		.bias             (bias),
		.scale_multiplier (scale_multiplier),
		.scale_shift      (scale_shift),
		.last_of_run      (last_of_run),
		.cfg              (cfg_q),
		.qstat            (qstat),
		.push             (push),
		.job              (push_job)
	);

	i8dpr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	i8dpr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.cfg          (cfg_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.neuron_value (neuron_value)
	);

	// Queue never takes a neuron it has no room for
	assert property (@(posedge clk) disable iff (!arst_n) !(push && qstat.full))
		else $error("push into full queue");

	// Back end never reads an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && qstat.empty))
		else $error("pop from empty queue");

	// A finished neuron is waiting in the queue right after its last pair
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_of_run) |=> !qstat.empty)
		else $error("finished neuron lost");

endmodule
